@@ rtl/cges_pkg.sv @@
// shared types, constants and saturation helpers for the central gravity euler step
// no dependencies
package cges_pkg;

  typedef enum logic [1:0] {
    REG_ATTRACT_X,
    REG_ATTRACT_Y,
    REG_CENTRAL_MASS,
    REG_GRAV_CONST
  } reg_idx_t;

  localparam logic [30:0] ATTRACT_X_RST    = 31'd671088640;
  localparam logic [30:0] ATTRACT_Y_RST    = 31'd671088640;
  localparam logic [19:0] CENTRAL_MASS_RST = 20'd100000;
  localparam logic [15:0] GRAV_CONST_RST   = 16'd6554;

  localparam int SQ_STEPS   = 33;
  localparam int DIV_STEPS  = 32;
  localparam int VDIV_STEPS = 40;
  localparam int NUM0_W     = 84;
  localparam int DEN0_W     = 98;

  localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] LIM_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [1:0][31:0] pos;
    logic [1:0][31:0] vel;
    logic [1:0][31:0] ad;
    logic [1:0][31:0] frc;
    logic [1:0]       sgn;
    logic [15:0]      bm;
    logic [64:0]      s;
    logic [51:0]      k;
    logic             center;
    logic             sat;
  } side_t;

  function automatic logic ovf32(input logic signed [47:0] x);
    return (x > $signed(48'h0000_7FFF_FFFF)) || (x < $signed(48'hFFFF_8000_0000));
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [47:0] x);
    logic [31:0] r;
    if (x > $signed(48'h0000_7FFF_FFFF)) begin
      r = LIM_POS;
    end else if (x < $signed(48'hFFFF_8000_0000)) begin
      r = LIM_NEG;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/central_gravity_euler_step.sv @@
// Pipelined point-mass gravity force and semi-implicit Euler step (position advanced with the new velocity).
// Takes one body per clock while the output is not stalled. The pipeline is built mainly from three
// shift-subtract units laid out as pipeline stages: a 33-step square root of the squared
// distance, a 32-step divider per axis for the force and a 40-step divider per axis for force
// over body mass. A stall at the output freezes the whole pipeline and holds off new bodies.
// The user must write registers over the APB port only while no body is in flight; the block itself
// does not enforce this. No clearing pass after reset. Depends on cges_pkg.
module central_gravity_euler_step #(
  parameter int POS_FRAC_BITS = 12,
  parameter int VEL_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        body_valid,
  output logic        body_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic [15:0] body_mass,
  output logic        result_valid,
  input  logic        result_stall,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic        at_center,
  output logic        saturated
);
  import cges_pkg::*;

  localparam int FSHIFT = 2 * POS_FRAC_BITS + VEL_FRAC_BITS - 24;
  localparam int FSP    = (FSHIFT > 0) ? FSHIFT : 0;
  localparam int FSN    = (FSHIFT < 0) ? -FSHIFT : 0;
  localparam int NUM_W  = NUM0_W + FSP;
  localparam int DEN_W  = DEN0_W + FSN;
  localparam int HI_W   = (NUM_W - 32 > DEN_W) ? NUM_W - 32 : DEN_W;
  localparam int VP_SHR = (VEL_FRAC_BITS >= POS_FRAC_BITS) ? VEL_FRAC_BITS - POS_FRAC_BITS : 0;
  localparam int VP_SHL = (POS_FRAC_BITS > VEL_FRAC_BITS) ? POS_FRAC_BITS - VEL_FRAC_BITS : 0;

  localparam int ST_P1 = 2 + SQ_STEPS + 1;
  localparam int ST_P2 = ST_P1 + 1;
  localparam int ST_D0 = ST_P2 + 1;
  localparam int ST_F  = ST_D0 + DIV_STEPS + 1;
  localparam int ST_N1 = ST_F + VDIV_STEPS + 1;
  localparam int ST_N2 = ST_N1 + 1;
  localparam int NST   = ST_N2 + 1;

  // configuration registers
  logic [30:0] attract_x;
  logic [30:0] attract_y;
  logic [19:0] central_mass;
  logic [15:0] grav_const;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attract_x    <= ATTRACT_X_RST;
      attract_y    <= ATTRACT_Y_RST;
      central_mass <= CENTRAL_MASS_RST;
      grav_const   <= GRAV_CONST_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_ATTRACT_X:    attract_x    <= pwdata[30:0];
        REG_ATTRACT_Y:    attract_y    <= pwdata[30:0];
        REG_CENTRAL_MASS: central_mass <= pwdata[19:0];
        REG_GRAV_CONST:   grav_const   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_ATTRACT_X:    prdata = {1'b0, attract_x};
      REG_ATTRACT_Y:    prdata = {1'b0, attract_y};
      REG_CENTRAL_MASS: prdata = {12'b0, central_mass};
      REG_GRAV_CONST:   prdata = {16'b0, grav_const};
      default:          prdata = '0;
    endcase
  end

  // pipeline control
  logic  valid [NST];
  side_t side  [NST];
  logic  en;

  assign en         = !(valid[NST-1] && result_stall);
  assign body_stall = !en;

  // stage 0: offsets to the center, first mass product
  logic signed [33:0] dx_c, dy_c;
  side_t s0_side;

  assign dx_c = $signed({3'b000, attract_x}) - $signed({{2{pos_x[31]}}, pos_x});
  assign dy_c = $signed({3'b000, attract_y}) - $signed({{2{pos_y[31]}}, pos_y});

  always_comb begin
    s0_side        = '0;
    s0_side.pos[0] = pos_x;
    s0_side.pos[1] = pos_y;
    s0_side.vel[0] = vel_x;
    s0_side.vel[1] = vel_y;
    s0_side.bm     = body_mass;
    s0_side.sgn    = {dy_c[33], dx_c[33]};
    s0_side.ad[0]  = dx_c[33] ? 32'(-dx_c) : dx_c[31:0];
    s0_side.ad[1]  = dy_c[33] ? 32'(-dy_c) : dy_c[31:0];
    s0_side.k      = 52'({16'b0, body_mass} * {16'b0, grav_const});
  end

  // stage 1: squares and full mass product
  logic [63:0] sqx, sqy;
  side_t s1_side;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= 64'(side[0].ad[0]) * 64'(side[0].ad[0]);
      sqy <= 64'(side[0].ad[1]) * 64'(side[0].ad[1]);
    end
  end

  always_comb begin
    s1_side   = side[0];
    s1_side.k = 52'(side[0].k[31:0]) * 52'(central_mass);
  end

  // stage 2: squared distance
  logic [64:0] s_sum;
  side_t s2_side;

  assign s_sum = 65'(sqx) + 65'(sqy);

  always_comb begin
    s2_side        = side[1];
    s2_side.s      = s_sum;
    s2_side.center = (s_sum == '0);
  end

  // square root, one result bit per stage
  logic [65:0] sq_op  [1:SQ_STEPS];
  logic [65:0] sq_res [1:SQ_STEPS];

  for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
    localparam logic [65:0] ONE = 66'(1) << (2 * (SQ_STEPS - j));
    logic [65:0] op_in, res_in, trial;

    if (j == 1) begin : g_first
      assign op_in  = 66'(side[2].s);
      assign res_in = '0;
    end else begin : g_next
      assign op_in  = sq_op[j-1];
      assign res_in = sq_res[j-1];
    end

    assign trial = res_in + ONE;

    always_ff @(posedge clk) begin
      if (en) begin
        if (op_in >= trial) begin
          sq_op[j]  <= op_in - trial;
          sq_res[j] <= (res_in >> 1) + ONE;
        end else begin
          sq_op[j]  <= op_in;
          sq_res[j] <= res_in >> 1;
        end
      end
    end
  end

  // partial products of the denominator and numerators
  logic [54:0] pd0, pd1;
  logic [53:0] pd2;
  logic [57:0] nx0 [2];
  logic [57:0] nx1 [2];
  logic [32:0] root;

  assign root = sq_res[SQ_STEPS][32:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pd0 <= 55'(side[ST_P1-1].s[21:0]) * 55'(root);
      pd1 <= 55'(side[ST_P1-1].s[43:22]) * 55'(root);
      pd2 <= 54'(side[ST_P1-1].s[64:44]) * 54'(root);
      for (int a = 0; a < 2; a++) begin
        nx0[a] <= 58'(side[ST_P1-1].k[25:0]) * 58'(side[ST_P1-1].ad[a]);
        nx1[a] <= 58'(side[ST_P1-1].k[51:26]) * 58'(side[ST_P1-1].ad[a]);
      end
    end
  end

  // partial product sums and fixed point alignment
  logic [DEN0_W-1:0] den_c;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  num_r [2];

  assign den_c = 98'(pd0) + (98'(pd1) << 22) + (98'(pd2) << 44);

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= DEN_W'(den_c) << FSN;
      for (int a = 0; a < 2; a++) begin
        num_r[a] <= NUM_W'(84'(nx0[a]) + (84'(nx1[a]) << 26)) << FSP;
      end
    end
  end

  // force divider, one quotient bit per stage
  logic [DEN_W-1:0] drem [0:DIV_STEPS][2];
  logic [31:0]      dlo  [0:DIV_STEPS][2];
  logic [31:0]      dq   [0:DIV_STEPS][2];
  logic             dovf [0:DIV_STEPS][2];
  logic [DEN_W-1:0] dden [0:DIV_STEPS];
  logic [HI_W-1:0]  hi   [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      hi[a] = HI_W'(num_r[a] >> 32);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dden[0] <= den_r;
      for (int a = 0; a < 2; a++) begin
        drem[0][a] <= hi[a][DEN_W-1:0];
        dlo[0][a]  <= num_r[a][31:0];
        dq[0][a]   <= '0;
        dovf[0][a] <= (hi[a] >= HI_W'(den_r));
      end
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [DEN_W:0] t  [2];
    logic           ge [2];

    always_comb begin
      for (int a = 0; a < 2; a++) begin
        t[a]  = {drem[j-1][a], dlo[j-1][a][31]};
        ge[a] = (t[a] >= {1'b0, dden[j-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dden[j] <= dden[j-1];
        for (int a = 0; a < 2; a++) begin
          drem[j][a] <= ge[a] ? DEN_W'(t[a] - {1'b0, dden[j-1]}) : t[a][DEN_W-1:0];
          dlo[j][a]  <= dlo[j-1][a] << 1;
          dq[j][a]   <= {dq[j-1][a][30:0], ge[a]};
          dovf[j][a] <= dovf[j-1][a];
        end
      end
    end
  end

  // force clamp and sign
  logic [31:0] f_lim [2];
  logic        f_big [2];
  logic [31:0] f_mag [2];
  side_t       f_side;

  always_comb begin
    f_side = side[ST_F-1];
    for (int a = 0; a < 2; a++) begin
      f_lim[a]      = f_side.sgn[a] ? LIM_NEG : LIM_POS;
      f_big[a]      = dovf[DIV_STEPS][a] || (dq[DIV_STEPS][a] > f_lim[a]);
      f_mag[a]      = f_side.center ? '0 : (f_big[a] ? f_lim[a] : dq[DIV_STEPS][a]);
      f_side.frc[a] = f_side.sgn[a] ? 32'(32'd0 - f_mag[a]) : f_mag[a];
      f_side.sat    = f_side.sat | (!f_side.center && f_big[a]);
    end
  end

  // velocity change divider, one quotient bit per stage
  logic [15:0] vrem [0:VDIV_STEPS][2];
  logic [39:0] vlo  [0:VDIV_STEPS][2];
  logic [39:0] vq   [0:VDIV_STEPS][2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        vrem[0][a] <= '0;
        vlo[0][a]  <= {f_mag[a], 8'b0};
        vq[0][a]   <= '0;
      end
    end
  end

  for (genvar j = 1; j <= VDIV_STEPS; j++) begin : g_vdiv
    logic [16:0] t  [2];
    logic        ge [2];

    always_comb begin
      for (int a = 0; a < 2; a++) begin
        t[a]  = {vrem[j-1][a], vlo[j-1][a][39]};
        ge[a] = (t[a] >= {1'b0, side[ST_F+j-1].bm});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int a = 0; a < 2; a++) begin
          vrem[j][a] <= ge[a] ? 16'(t[a] - {1'b0, side[ST_F+j-1].bm}) : t[a][15:0];
          vlo[j][a]  <= vlo[j-1][a] << 1;
          vq[j][a]   <= {vq[j-1][a][38:0], ge[a]};
        end
      end
    end
  end

  // new velocity
  logic [39:0]        n1_dv  [2];
  logic signed [47:0] n1_sum [2];
  side_t              n1_side;

  always_comb begin
    n1_side = side[ST_N1-1];
    for (int a = 0; a < 2; a++) begin
      n1_dv[a]      = (n1_side.bm == '0) ? '0 : vq[VDIV_STEPS][a];
      n1_sum[a]     = 48'($signed(n1_side.vel[a])) +
                      (n1_side.frc[a][31] ? 48'(48'd0 - 48'(n1_dv[a])) : 48'(n1_dv[a]));
      n1_side.vel[a] = clamp32(n1_sum[a]);
      n1_side.sat    = n1_side.sat | ovf32(n1_sum[a]);
    end
  end

  // new position
  logic signed [47:0] n2_vw  [2];
  logic signed [47:0] n2_sum [2];
  side_t              n2_side;

  always_comb begin
    n2_side = side[ST_N2-1];
    for (int a = 0; a < 2; a++) begin
      n2_vw[a]       = (48'($signed(n2_side.vel[a])) <<< VP_SHL) >>> VP_SHR;
      n2_sum[a]      = 48'($signed(n2_side.pos[a])) + n2_vw[a];
      n2_side.pos[a] = clamp32(n2_sum[a]);
      n2_side.sat    = n2_side.sat | ovf32(n2_sum[a]);
    end
  end

  // valid and side-band chain
  for (genvar i = 0; i < NST; i++) begin : g_stage
    side_t side_d;

    if (i == 0) begin : g_s0
      assign side_d = s0_side;
    end else if (i == 1) begin : g_s1
      assign side_d = s1_side;
    end else if (i == 2) begin : g_s2
      assign side_d = s2_side;
    end else if (i == ST_F) begin : g_f
      assign side_d = f_side;
    end else if (i == ST_N1) begin : g_n1
      assign side_d = n1_side;
    end else if (i == ST_N2) begin : g_n2
      assign side_d = n2_side;
    end else begin : g_pass
      assign side_d = side[i-1];
    end

    if (i == 0) begin : g_v0
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[i] <= 1'b0;
        end else if (en) begin
          valid[i] <= body_valid;
        end
        if (en) begin
          side[i] <= side_d;
        end
      end
    end else begin : g_vn
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[i] <= 1'b0;
        end else if (en) begin
          valid[i] <= valid[i-1];
        end
        if (en) begin
          side[i] <= side_d;
        end
      end
    end
  end

  assign result_valid = valid[NST-1];
  assign new_pos_x    = side[NST-1].pos[0];
  assign new_pos_y    = side[NST-1].pos[1];
  assign new_vel_x    = side[NST-1].vel[0];
  assign new_vel_y    = side[NST-1].vel[1];
  assign force_x      = side[NST-1].frc[0];
  assign force_y      = side[NST-1].frc[1];
  assign at_center    = side[NST-1].center;
  assign saturated    = side[NST-1].sat;

  a_center_no_force: assert property (@(posedge clk) disable iff (rst)
    result_valid && at_center |-> force_x == 32'sd0 && force_y == 32'sd0)
    else $error("force not zero at center");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    body_stall |-> result_valid && result_stall)
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule
